### hdl/rocca_pkg.sv
// rocca-s package: shared types, constants and the aes round function
// no dependencies
package rocca_pkg;

  typedef enum logic [1:0] {
    OP_AD     = 2'd0,
    OP_MSG    = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_K0_HI = 3'd0,
    CFG_K0_LO = 3'd1,
    CFG_K1_HI = 3'd2,
    CFG_K1_LO = 3'd3,
    CFG_N_HI  = 3'd4,
    CFG_N_LO  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_KEYMIX,
    ST_WORK,
    ST_FIN,
    ST_OUT
  } state_e;

  localparam int unsigned NumRounds = 16;
  localparam int unsigned RndW = $clog2(NumRounds);

  localparam logic [127:0] Z0 = 128'hcd65ef2391443771_22ae28d7982f8a42;
  localparam logic [127:0] Z1 = 128'hbcdb8981a5dbb5e9_2f3b4deccffbc0b5;

  typedef logic [127:0] blk_t;

  typedef struct packed {
    blk_t s0, s1, s2, s3, s4, s5, s6;
  } rstate_t;

  // control from sequencer to the round datapath
  typedef struct packed {
    logic load;
    logic round;
    logic keymix;
  } dp_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // one aes round: subbytes, shiftrows, mixcolumns, add round key
  // byte 0 is the most significant byte
  function automatic blk_t aes_round(input blk_t x, input blk_t rk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    blk_t r;
    for (int i = 0; i < 16; i++) begin
      s[i] = SBOX[x[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int rw = 0; rw < 4; rw++) begin
        t[rw+4*c] = s[rw+4*((c+rw)%4)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      r[127-32*c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      r[119-32*c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      r[111-32*c -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      r[103-32*c -: 8]  = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    aes_round = r ^ rk;
  endfunction

  function automatic logic [63:0] swap_bytes(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[63-8*i -: 8];
    end
    swap_bytes = r;
  endfunction

endpackage

### hdl/rocca_if.sv
// handshake channel interfaces for the rocca-s block
// depends on nothing
interface rocca_in_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] block_word0;
  logic [63:0] block_word1;
  logic [63:0] block_word2;
  logic [63:0] block_word3;
  logic [63:0] ad_bits;
  logic [63:0] msg_bits;
  modport source (output valid, operation, block_word0, block_word1, block_word2,
                  block_word3, ad_bits, msg_bits, input ready);
  modport sink (input valid, operation, block_word0, block_word1, block_word2,
                block_word3, ad_bits, msg_bits, output ready);
endinterface

interface rocca_out_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [63:0] out_word0;
  logic [63:0] out_word1;
  logic [63:0] out_word2;
  logic [63:0] out_word3;
  modport source (output valid, result_kind, out_word0, out_word1, out_word2,
                  out_word3, input ready);
  modport sink (input valid, result_kind, out_word0, out_word1, out_word2,
                out_word3, output ready);
endinterface

interface rocca_cfg_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/rocca_s_aead_encrypt.sv
// rocca-s encryption top level: sequencer, configuration registers, output register
// depends on rocca_pkg, rocca_if and rocca_round
//
// One item is taken at a time; ready stays low until its result, if any, has
// been taken. The state update runs once per clock in the init, work and
// finish states, in one shared round unit of six aes rounds. An
// associated-data item runs one round; a message item runs one round and then
// waits for the output handshake. The first item of a session adds 16 init
// rounds and a key mix step; a finish item runs 16 rounds and then outputs the
// tag. Operation code 3 is dropped without a round. Register writes are used
// at the next session start and should only be made while no item is in flight.
module rocca_s_aead_encrypt (
  input  logic   clk_i,
  input  logic   rst_ni,
  rocca_in_if.sink    in_i,
  rocca_out_if.source out_o,
  rocca_cfg_if.sink   cfg_i
);
  import rocca_pkg::*;

  state_e      state_q, state_d;
  logic [RndW-1:0] cnt_q, cnt_d;
  logic        open_q, open_d;
  logic [63:0] cfg_q [6];
  op_e         op_q;
  blk_t        x0_q, x1_q, la_q, lm_q;
  logic        okind_q;
  blk_t        oc0_q, oc1_q;
  logic        oset;
  dp_ctrl_t    ctrl;
  rstate_t     st, ld;
  blk_t        k0, k1, nn, rx0, rx1, c0, c1;
  logic        in_acc;

  assign k0 = {cfg_q[CFG_K0_HI], cfg_q[CFG_K0_LO]};
  assign k1 = {cfg_q[CFG_K1_HI], cfg_q[CFG_K1_LO]};
  assign nn = {cfg_q[CFG_N_HI], cfg_q[CFG_N_LO]};

  // config writes always accepted, out-of-range index ignored
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) cfg_q[i] <= '0;
    end else if (cfg_i.valid && cfg_i.index <= CFG_N_LO) begin
      cfg_q[cfg_i.index] <= cfg_i.data;
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc = in_i.valid && in_i.ready;

  // initial state load
  assign ld = '{s0: k1, s1: nn, s2: Z0, s3: k0, s4: Z1, s5: nn ^ k1, s6: '0};

  // round key select for the shared unit
  always_comb begin
    rx0 = x0_q;
    rx1 = x1_q;
    unique case (state_q)
      ST_INIT: begin rx0 = Z0;   rx1 = Z1;   end
      ST_FIN:  begin rx0 = la_q; rx1 = lm_q; end
      default: ;
    endcase
  end

  // ciphertext taken from the state before the message round
  assign c0 = aes_round(st.s3 ^ st.s5, st.s0) ^ x0_q;
  assign c1 = aes_round(st.s4 ^ st.s6, st.s2) ^ x1_q;

  rocca_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .load_i (ld),
    .x0_i   (rx0),
    .x1_i   (rx1),
    .k0_i   (k0),
    .k1_i   (k1),
    .state_o(st)
  );

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    open_d  = open_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && op_e'(in_i.operation) != OP_NONE) begin
          cnt_d = '0;
          if (!open_q) state_d = ST_INIT;
          else if (op_e'(in_i.operation) == OP_FINISH) state_d = ST_FIN;
          else state_d = ST_WORK;
        end
      end
      ST_INIT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RndW'(NumRounds - 1)) state_d = ST_KEYMIX;
      end
      ST_KEYMIX: begin
        open_d = 1'b1;
        cnt_d  = '0;
        state_d = (op_q == OP_FINISH) ? ST_FIN : ST_WORK;
      end
      ST_WORK: begin
        state_d = (op_q == OP_MSG) ? ST_OUT : ST_IDLE;
      end
      ST_FIN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RndW'(NumRounds - 1)) begin
          state_d = ST_OUT;
          open_d  = 1'b0;
        end
      end
      ST_OUT: begin
        if (out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ctrl = '0;
    oset = 1'b0;
    unique case (state_q)
      ST_IDLE:   ctrl.load = in_acc && !open_q && op_e'(in_i.operation) != OP_NONE;
      ST_INIT:   ctrl.round = 1'b1;
      ST_KEYMIX: ctrl.keymix = 1'b1;
      ST_WORK: begin
        ctrl.round = 1'b1;
        oset = (op_q == OP_MSG);
      end
      ST_FIN:    ctrl.round = 1'b1;
      ST_OUT:    ;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      open_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      open_q  <= open_d;
    end
  end

  // item payload capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= op_e'(in_i.operation);
      x0_q <= {in_i.block_word0, in_i.block_word1};
      x1_q <= {in_i.block_word2, in_i.block_word3};
      la_q <= {swap_bytes(in_i.ad_bits), 64'd0};
      lm_q <= {swap_bytes(in_i.msg_bits), 64'd0};
    end
  end

  // output register: message-round ciphertext, result kind after finish
  always_ff @(posedge clk_i) begin
    if (oset) begin
      okind_q <= 1'b0;
      oc0_q   <= c0;
      oc1_q   <= c1;
    end else if (state_q == ST_FIN && cnt_q == RndW'(NumRounds - 1)) begin
      okind_q <= 1'b1;
    end
  end

  // tag is formed from the live state once the finish rounds are done
  blk_t t0, t1;
  assign t0 = st.s0 ^ st.s1 ^ st.s2 ^ st.s3;
  assign t1 = st.s4 ^ st.s5 ^ st.s6;

  assign out_o.valid       = (state_q == ST_OUT);
  assign out_o.result_kind = okind_q;
  assign out_o.out_word0   = okind_q ? t0[127:64] : oc0_q[127:64];
  assign out_o.out_word1   = okind_q ? t0[63:0]   : oc0_q[63:0];
  assign out_o.out_word2   = okind_q ? t1[127:64] : oc1_q[127:64];
  assign out_o.out_word3   = okind_q ? t1[63:0]   : oc1_q[63:0];

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_i.ready) else $error("ready while busy");
  a_fin_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && state_d == ST_OUT) |=> !open_q) else $error("session left open");
  a_keymix_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_KEYMIX |=> open_q) else $error("session not opened");
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> state_q == ST_OUT) else $error("stray output");

endmodule

### hdl/rocca_round.sv
// rocca-s state register and shared round unit (six aes rounds per step)
// depends on rocca_pkg
module rocca_round (
  input  logic                clk_i,
  input  rocca_pkg::dp_ctrl_t ctrl_i,
  input  rocca_pkg::rstate_t  load_i,
  input  rocca_pkg::blk_t     x0_i,
  input  rocca_pkg::blk_t     x1_i,
  input  rocca_pkg::blk_t     k0_i,
  input  rocca_pkg::blk_t     k1_i,
  output rocca_pkg::rstate_t  state_o
);
  import rocca_pkg::*;

  rstate_t st_q, st_d, rnd;

  always_comb begin
    rnd.s0 = st_q.s6 ^ st_q.s1;
    rnd.s1 = aes_round(st_q.s0, x0_i);
    rnd.s2 = aes_round(st_q.s1, st_q.s0);
    rnd.s3 = aes_round(st_q.s2, st_q.s6);
    rnd.s4 = aes_round(st_q.s3, x1_i);
    rnd.s5 = aes_round(st_q.s4, st_q.s3);
    rnd.s6 = aes_round(st_q.s5, st_q.s4);
  end

  always_comb begin
    st_d = st_q;
    if (ctrl_i.load) begin
      st_d = load_i;
    end else if (ctrl_i.round) begin
      st_d = rnd;
    end else if (ctrl_i.keymix) begin
      st_d.s0 = st_q.s0 ^ k0_i;
      st_d.s1 = st_q.s1 ^ k0_i;
      st_d.s2 = st_q.s2 ^ k1_i;
      st_d.s3 = st_q.s3 ^ k0_i;
      st_d.s4 = st_q.s4 ^ k0_i;
      st_d.s5 = st_q.s5 ^ k1_i;
      st_d.s6 = st_q.s6 ^ k1_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign state_o = st_q;

endmodule
